// ===== sv/qevt_pkg.sv =====
// ----------------------------------------------------------------------------
// qevt_pkg: shared types and constants of the encoder value tracker
// Transfer payloads, register map, event codes, sequencer states and the
// quadrature transition table.
// ----------------------------------------------------------------------------
package qevt_pkg;

   localparam int DATA_W  = 32;  // config data bus
   localparam int ADDR_W  = 5;   // eight 32-bit registers
   localparam int VALUE_W = 16;  // tracked value and bounds
   localparam int THR_W   = 16;  // speed thresholds
   localparam int MULT_W  = 4;   // speed multipliers
   localparam int DELTA_W = 13;  // signed step delta, up to 255*9
   localparam int SUM_W   = 19;  // range unit datapath
   localparam int MAG_W   = 17;  // magnitude of value minus low bound

   // config register indexes
   localparam logic [2:0] REG_MIN_VALUE   = 3'd0;
   localparam logic [2:0] REG_MAX_VALUE   = 3'd1;
   localparam logic [2:0] REG_WRAP_ENABLE = 3'd2;
   localparam logic [2:0] REG_MEDIUM_THR  = 3'd3;
   localparam logic [2:0] REG_FAST_THR    = 3'd4;
   localparam logic [2:0] REG_MEDIUM_MULT = 3'd5;
   localparam logic [2:0] REG_FAST_MULT   = 3'd6;
   localparam logic [2:0] REG_ACCEL_EN    = 3'd7;

   // input actions
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_LOAD   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // result event kinds
   localparam logic [1:0] EVT_INC     = 2'd0;
   localparam logic [1:0] EVT_DEC     = 2'd1;
   localparam logic [1:0] EVT_PRESS   = 2'd2;
   localparam logic [1:0] EVT_RELEASE = 2'd3;

   typedef struct packed {
      logic [1:0]                action;
      logic                      phase_a;
      logic                      phase_b;
      logic                      button_raw;
      logic [31:0]               now_ms;
      logic signed [VALUE_W-1:0] load_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                event_kind;
      logic signed [VALUE_W-1:0] current_value;
      logic                      last_of_run;
   } rsp_payload_type;

   // command into the wrap/clamp unit
   typedef struct packed {
      logic                      start;
      logic                      wrap;
      logic signed [VALUE_W-1:0] base;
      logic signed [DELTA_W-1:0] delta;
   } range_cmd_type;

   // status back from the wrap/clamp unit
   typedef struct packed {
      logic                      done;
      logic signed [VALUE_W-1:0] value;
   } range_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TIME,
      ST_LOAD,
      ST_RANGE,
      ST_BUTTON,
      ST_EMIT_ROT,
      ST_EMIT_BTN
   } main_state_type;

   typedef enum logic [3:0] {
      RU_IDLE,
      RU_SUM,
      RU_CL_HI,
      RU_CL_LO,
      RU_DIFF,
      RU_SPAN,
      RU_ABS,
      RU_DIV,
      RU_FIX,
      RU_FINAL
   } range_state_type;

   // half-step delta for {previous pair, current pair}
   function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: d = 2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/qevt_range_unit.sv =====
// ----------------------------------------------------------------------------
// qevt_range_unit: wrap or clamp of a value into lo..hi
// One shared adder under a small sequencer: sum, then either two clamp
// compares or a restoring remainder loop for the wrap case.
// ----------------------------------------------------------------------------
module qevt_range_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  qevt_pkg::range_cmd_type               cmd,
   input  logic signed [qevt_pkg::VALUE_W-1:0]   lo,
   input  logic signed [qevt_pkg::VALUE_W-1:0]   hi,
   output qevt_pkg::range_rsp_type               rsp
);

   localparam int AW    = qevt_pkg::SUM_W;
   localparam int VW    = qevt_pkg::VALUE_W;
   localparam int MW    = qevt_pkg::MAG_W;
   localparam int DW    = qevt_pkg::DELTA_W;
   localparam int CNT_W = $clog2(MW);

   qevt_pkg::range_state_type state_ff, state_in;

   logic                   done_ff;
   logic signed [VW-1:0]   result_ff;
   logic                   wrap_ff;
   logic signed [VW-1:0]   base_ff;
   logic signed [DW-1:0]   delta_ff;
   logic signed [AW-1:0]   val_ff;
   logic [VW-1:0]          span_ff;
   logic [MW-1:0]          mag_ff;
   logic [VW-1:0]          rem_ff;
   logic                   neg_ff;
   logic                   plus1_ff;
   logic [CNT_W-1:0]       cnt_ff;

   logic signed [AW-1:0]   lo_x, hi_x;
   logic signed [AW-1:0]   alu_a, alu_b, alu_sum;
   logic                   alu_cin;
   logic                   alu_neg;

   assign lo_x    = {{(AW-VW){lo[VW-1]}}, lo};
   assign hi_x    = {{(AW-VW){hi[VW-1]}}, hi};
   assign alu_sum = alu_a + alu_b + {{(AW-1){1'b0}}, alu_cin};
   assign alu_neg = alu_sum[AW-1];

   // shared adder operand select
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_cin = 1'b0;
      case (state_ff)
         qevt_pkg::RU_SUM: begin
            alu_a = {{(AW-VW){base_ff[VW-1]}}, base_ff};
            alu_b = {{(AW-DW){delta_ff[DW-1]}}, delta_ff};
         end
         qevt_pkg::RU_CL_HI: begin
            alu_a   = hi_x;
            alu_b   = ~val_ff;
            alu_cin = 1'b1;
         end
         qevt_pkg::RU_CL_LO, qevt_pkg::RU_DIFF: begin
            alu_a   = val_ff;
            alu_b   = ~lo_x;
            alu_cin = 1'b1;
         end
         qevt_pkg::RU_SPAN: begin
            alu_a   = hi_x;
            alu_b   = ~lo_x;
            alu_cin = 1'b1;
         end
         qevt_pkg::RU_ABS: begin
            alu_b   = ~val_ff;
            alu_cin = 1'b1;
         end
         qevt_pkg::RU_DIV: begin
            // shifted remainder minus (span + 1)
            alu_a = {{(AW-VW-1){1'b0}}, rem_ff, mag_ff[MW-1]};
            alu_b = ~{{(AW-VW){1'b0}}, span_ff};
         end
         qevt_pkg::RU_FIX: begin
            alu_a   = {{(AW-VW){1'b0}}, span_ff};
            alu_b   = ~{{(AW-VW){1'b0}}, rem_ff};
            alu_cin = 1'b1;
         end
         qevt_pkg::RU_FINAL: begin
            alu_a   = lo_x;
            alu_b   = {{(AW-VW){1'b0}}, rem_ff};
            alu_cin = plus1_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qevt_pkg::RU_IDLE:  if (cmd.start) state_in = qevt_pkg::RU_SUM;
         qevt_pkg::RU_SUM:   state_in = wrap_ff ? qevt_pkg::RU_DIFF : qevt_pkg::RU_CL_HI;
         qevt_pkg::RU_CL_HI: state_in = alu_neg ? qevt_pkg::RU_IDLE : qevt_pkg::RU_CL_LO;
         qevt_pkg::RU_CL_LO: state_in = qevt_pkg::RU_IDLE;
         qevt_pkg::RU_DIFF:  state_in = qevt_pkg::RU_SPAN;
         qevt_pkg::RU_SPAN:  state_in = qevt_pkg::RU_ABS;
         qevt_pkg::RU_ABS:   state_in = qevt_pkg::RU_DIV;
         qevt_pkg::RU_DIV:   if (cnt_ff == '0) state_in = qevt_pkg::RU_FIX;
         qevt_pkg::RU_FIX:   state_in = qevt_pkg::RU_FINAL;
         qevt_pkg::RU_FINAL: state_in = qevt_pkg::RU_IDLE;
         default:            state_in = qevt_pkg::RU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qevt_pkg::RU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= ((state_ff == qevt_pkg::RU_CL_HI) && alu_neg)
                  || (state_ff == qevt_pkg::RU_CL_LO)
                  || (state_ff == qevt_pkg::RU_FINAL);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         qevt_pkg::RU_IDLE: begin
            if (cmd.start) begin
               wrap_ff  <= cmd.wrap;
               base_ff  <= cmd.base;
               delta_ff <= cmd.delta;
            end
         end
         qevt_pkg::RU_SUM: val_ff <= alu_sum;
         qevt_pkg::RU_CL_HI: begin
            if (alu_neg) result_ff <= hi;
         end
         qevt_pkg::RU_CL_LO: result_ff <= alu_neg ? lo : val_ff[VW-1:0];
         qevt_pkg::RU_DIFF: val_ff <= alu_sum;
         qevt_pkg::RU_SPAN: span_ff <= alu_sum[VW-1:0];
         qevt_pkg::RU_ABS: begin
            neg_ff <= val_ff[AW-1];
            mag_ff <= val_ff[AW-1] ? alu_sum[MW-1:0] : val_ff[MW-1:0];
            rem_ff <= '0;
            cnt_ff <= CNT_W'(MW - 1);
         end
         qevt_pkg::RU_DIV: begin
            rem_ff <= alu_neg ? {rem_ff[VW-2:0], mag_ff[MW-1]} : alu_sum[VW-1:0];
            mag_ff <= {mag_ff[MW-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
         qevt_pkg::RU_FIX: begin
            // negative offset with a remainder: range - rem = (span - rem) + 1
            plus1_ff <= neg_ff && (rem_ff != '0);
            if (neg_ff && (rem_ff != '0)) rem_ff <= alu_sum[VW-1:0];
         end
         qevt_pkg::RU_FINAL: result_ff <= alu_sum[VW-1:0];
         default: begin
            val_ff <= val_ff;
         end
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.value = result_ff;

endmodule

// ===== sv/quadrature_encoder_value_tracker_core.sv =====
// A pin sample with a step goes through the range unit, which clamps or, when
// wrapping, runs its remainder loop; each result then waits for the output register.
// A load is clamped there; a context clear or unused action ends at the transfer.
// One item at a time; req_stall stays high until the item's results are queued.
// Reset (synchronous) restores the config defaults and the tracker state.
// ----------------------------------------------------------------------------
// quadrature_encoder_value_tracker_core: quadrature encoder value tracker
// Decodes phase pin samples into steps, scales them by a speed dependent
// multiplier, wraps or clamps the tracked value and debounces the button.
// ----------------------------------------------------------------------------
module quadrature_encoder_value_tracker_core #(
   parameter int STEP_SIZE   = 1,    // 1..255
   parameter int DEBOUNCE_MS = 50    // 1..65535
) (
   input  logic                                clock,
   input  logic                                reset,
   // input item channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  qevt_pkg::req_payload_type           req_payload,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output qevt_pkg::rsp_payload_type           rsp_payload,
   // config port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [qevt_pkg::ADDR_W-1:0]         paddr,
   input  logic [qevt_pkg::DATA_W-1:0]         pwdata,
   output logic [qevt_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int VW  = qevt_pkg::VALUE_W;
   localparam int TW  = qevt_pkg::THR_W;
   localparam int MUW = qevt_pkg::MULT_W;
   localparam int DW  = qevt_pkg::DELTA_W;

   // ------------------------------------------------------------------
   // Config registers
   // ------------------------------------------------------------------
   logic signed [VW-1:0] min_value_ff, max_value_ff;
   logic                 wrap_enable_ff;
   logic [TW-1:0]        medium_thr_ff, fast_thr_ff;
   logic [MUW-1:0]       medium_mult_ff, fast_mult_ff;
   logic                 accel_enable_ff;

   logic                 csr_write;
   logic [2:0]           csr_index;
   logic                 mult_ok;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[qevt_pkg::ADDR_W-1:2];
   // multiplier writes outside 1..9 leave the register alone
   assign mult_ok   = (pwdata[MUW-1:0] inside {[4'd1:4'd9]});

   always_ff @(posedge clock) begin
      if (reset) begin
         min_value_ff    <= 16'sd0;
         max_value_ff    <= 16'sd255;
         wrap_enable_ff  <= 1'b1;
         medium_thr_ff   <= 16'd100;
         fast_thr_ff     <= 16'd40;
         medium_mult_ff  <= 4'd2;
         fast_mult_ff    <= 4'd3;
         accel_enable_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            qevt_pkg::REG_MIN_VALUE:   min_value_ff   <= pwdata[VW-1:0];
            qevt_pkg::REG_MAX_VALUE:   max_value_ff   <= pwdata[VW-1:0];
            qevt_pkg::REG_WRAP_ENABLE: wrap_enable_ff <= pwdata[0];
            // a zero threshold is stored as one
            qevt_pkg::REG_MEDIUM_THR:
               medium_thr_ff <= (pwdata[TW-1:0] == '0) ? TW'(1) : pwdata[TW-1:0];
            qevt_pkg::REG_FAST_THR:
               fast_thr_ff <= (pwdata[TW-1:0] == '0) ? TW'(1) : pwdata[TW-1:0];
            qevt_pkg::REG_MEDIUM_MULT: if (mult_ok) medium_mult_ff <= pwdata[MUW-1:0];
            qevt_pkg::REG_FAST_MULT:   if (mult_ok) fast_mult_ff <= pwdata[MUW-1:0];
            qevt_pkg::REG_ACCEL_EN:    accel_enable_ff <= pwdata[0];
            default:                   accel_enable_ff <= accel_enable_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         qevt_pkg::REG_MIN_VALUE:   prdata = {{(32-VW){min_value_ff[VW-1]}}, min_value_ff};
         qevt_pkg::REG_MAX_VALUE:   prdata = {{(32-VW){max_value_ff[VW-1]}}, max_value_ff};
         qevt_pkg::REG_WRAP_ENABLE: prdata = {31'b0, wrap_enable_ff};
         qevt_pkg::REG_MEDIUM_THR:  prdata = {{(32-TW){1'b0}}, medium_thr_ff};
         qevt_pkg::REG_FAST_THR:    prdata = {{(32-TW){1'b0}}, fast_thr_ff};
         qevt_pkg::REG_MEDIUM_MULT: prdata = {{(32-MUW){1'b0}}, medium_mult_ff};
         qevt_pkg::REG_FAST_MULT:   prdata = {{(32-MUW){1'b0}}, fast_mult_ff};
         qevt_pkg::REG_ACCEL_EN:    prdata = {31'b0, accel_enable_ff};
         default:                   prdata = '0;
      endcase
   end

   // bounds in order; min above max uses them swapped
   logic signed [VW-1:0] lo, hi;
   assign lo = (min_value_ff > max_value_ff) ? max_value_ff : min_value_ff;
   assign hi = (min_value_ff > max_value_ff) ? min_value_ff : max_value_ff;

   // ------------------------------------------------------------------
   // Tracker state and item latch
   // ------------------------------------------------------------------
   qevt_pkg::main_state_type  state_ff, state_in;
   qevt_pkg::req_payload_type item_ff;

   logic [1:0]           last_phase_ff;
   logic signed [2:0]    acc_ff;          // half steps, stays within -1..1
   logic signed [VW-1:0] tracked_ff;
   logic [31:0]          last_step_ff;    // 0 means no step yet
   logic                 raw_prev_ff;
   logic                 deb_ff;
   logic                 held_ff;
   logic [31:0]          change_time_ff;

   logic                 is_load_ff;
   logic                 step_dn_ff;
   logic                 rot_pend_ff;
   logic signed [VW-1:0] rot_value_ff;
   logic                 btn_pend_ff;
   logic [1:0]           btn_kind_ff;

   logic                      rsp_valid_ff;
   qevt_pkg::rsp_payload_type rsp_payload_ff;

   logic req_accept;
   assign req_accept = req_valid && (state_ff == qevt_pkg::ST_IDLE);

   // ------------------------------------------------------------------
   // Phase decode: at most one full step per sample
   // ------------------------------------------------------------------
   logic [1:0]        cur_pair;
   logic              moved;
   logic signed [1:0] half_delta;
   logic signed [2:0] acc_sum;
   logic              step_up, step_dn, take_step;

   always_comb begin
      cur_pair   = {item_ff.phase_a, item_ff.phase_b};
      moved      = (cur_pair != last_phase_ff);
      half_delta = qevt_pkg::quad_delta({last_phase_ff, cur_pair});
      acc_sum    = acc_ff + {half_delta[1], half_delta};
      step_up    = moved && (half_delta != 2'sd0) && (acc_sum == 3'sd2);
      step_dn    = moved && (half_delta != 2'sd0) && (acc_sum == -3'sd2);
      take_step  = step_up || step_dn;
   end

   // ------------------------------------------------------------------
   // Step timing and multiplier
   // ------------------------------------------------------------------
   logic [31:0]          elapsed;
   logic [MUW-1:0]       mult;
   logic [DW-2:0]        delta_mag;
   logic signed [DW-1:0] delta_val;

   always_comb begin
      elapsed = (last_step_ff == '0) ? 32'd1 : (item_ff.now_ms - last_step_ff);
      mult    = MUW'(1);
      if (accel_enable_ff && (elapsed != '0)) begin
         if (elapsed <= {{(32-TW){1'b0}}, fast_thr_ff})
            mult = fast_mult_ff;
         else if (elapsed <= {{(32-TW){1'b0}}, medium_thr_ff})
            mult = medium_mult_ff;
      end
      delta_mag = (DW-1)'(STEP_SIZE) * {{(DW-1-MUW){1'b0}}, mult};
      delta_val = step_dn_ff ? -$signed({1'b0, delta_mag}) : $signed({1'b0, delta_mag});
   end

   // ------------------------------------------------------------------
   // Button debounce
   // ------------------------------------------------------------------
   logic [31:0] since_change;
   logic        raw_moved, settle, press, release_evt;

   always_comb begin
      since_change = item_ff.now_ms - change_time_ff;
      raw_moved    = (item_ff.button_raw != raw_prev_ff);
      settle       = !raw_moved && (item_ff.button_raw != deb_ff)
                  && (since_change > 32'(DEBOUNCE_MS));
      press        = settle && !held_ff && !item_ff.button_raw;
      release_evt  = settle && held_ff && item_ff.button_raw;
   end

   // ------------------------------------------------------------------
   // Wrap / clamp unit
   // ------------------------------------------------------------------
   qevt_pkg::range_cmd_type rng_cmd;
   qevt_pkg::range_rsp_type rng_rsp;

   qevt_range_unit u_range (
      .clock (clock),
      .reset (reset),
      .cmd   (rng_cmd),
      .lo    (lo),
      .hi    (hi),
      .rsp   (rng_rsp)
   );

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qevt_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_payload.action)
                  qevt_pkg::ACT_SAMPLE: state_in = qevt_pkg::ST_DECODE;
                  qevt_pkg::ACT_LOAD:   state_in = qevt_pkg::ST_LOAD;
                  default:              state_in = qevt_pkg::ST_IDLE;
               endcase
            end
         end
         qevt_pkg::ST_DECODE:
            state_in = take_step ? qevt_pkg::ST_TIME : qevt_pkg::ST_BUTTON;
         qevt_pkg::ST_TIME: state_in = qevt_pkg::ST_RANGE;
         qevt_pkg::ST_LOAD: state_in = qevt_pkg::ST_RANGE;
         qevt_pkg::ST_RANGE: begin
            if (rng_rsp.done)
               state_in = is_load_ff ? qevt_pkg::ST_IDLE : qevt_pkg::ST_BUTTON;
         end
         qevt_pkg::ST_BUTTON: begin
            if (rot_pend_ff)                state_in = qevt_pkg::ST_EMIT_ROT;
            else if (press || release_evt)  state_in = qevt_pkg::ST_EMIT_BTN;
            else                            state_in = qevt_pkg::ST_IDLE;
         end
         qevt_pkg::ST_EMIT_ROT: begin
            if (out_free)
               state_in = btn_pend_ff ? qevt_pkg::ST_EMIT_BTN : qevt_pkg::ST_IDLE;
         end
         qevt_pkg::ST_EMIT_BTN: if (out_free) state_in = qevt_pkg::ST_IDLE;
         default: state_in = qevt_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: outputs
   // ------------------------------------------------------------------
   logic                      rsp_load;
   qevt_pkg::rsp_payload_type rsp_next;

   always_comb begin
      req_stall      = (state_ff != qevt_pkg::ST_IDLE);
      rng_cmd.start  = 1'b0;
      rng_cmd.wrap   = 1'b0;
      rng_cmd.base   = tracked_ff;
      rng_cmd.delta  = delta_val;
      rsp_load       = 1'b0;
      rsp_next.event_kind    = qevt_pkg::EVT_INC;
      rsp_next.current_value = rot_value_ff;
      rsp_next.last_of_run   = 1'b1;
      case (state_ff)
         qevt_pkg::ST_TIME: begin
            rng_cmd.start = 1'b1;
            rng_cmd.wrap  = wrap_enable_ff;
         end
         qevt_pkg::ST_LOAD: begin
            // load is always clamped
            rng_cmd.start = 1'b1;
            rng_cmd.base  = item_ff.load_value;
            rng_cmd.delta = '0;
         end
         qevt_pkg::ST_EMIT_ROT: begin
            rsp_load               = out_free;
            rsp_next.event_kind    = step_dn_ff ? qevt_pkg::EVT_DEC : qevt_pkg::EVT_INC;
            rsp_next.last_of_run   = !btn_pend_ff;
         end
         qevt_pkg::ST_EMIT_BTN: begin
            rsp_load               = out_free;
            rsp_next.event_kind    = btn_kind_ff;
            rsp_next.current_value = '0;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= qevt_pkg::ST_IDLE;
         last_phase_ff  <= 2'b11;
         acc_ff         <= 3'sd0;
         tracked_ff     <= 16'sd0;
         last_step_ff   <= '0;
         raw_prev_ff    <= 1'b1;
         deb_ff         <= 1'b1;
         held_ff        <= 1'b0;
         change_time_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         rot_pend_ff    <= 1'b0;
         btn_pend_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            qevt_pkg::ST_IDLE: begin
               // context clear happens right at the transfer
               if (req_accept && (req_payload.action == qevt_pkg::ACT_CLEAR)) begin
                  acc_ff       <= 3'sd0;
                  last_step_ff <= '0;
               end
            end
            qevt_pkg::ST_DECODE: begin
               rot_pend_ff <= 1'b0;
               btn_pend_ff <= 1'b0;
               if (moved) last_phase_ff <= cur_pair;
               if (half_delta != 2'sd0) acc_ff <= take_step ? 3'sd0 : acc_sum;
            end
            qevt_pkg::ST_TIME: last_step_ff <= item_ff.now_ms;
            qevt_pkg::ST_RANGE: begin
               if (rng_rsp.done) begin
                  tracked_ff  <= rng_rsp.value;
                  rot_pend_ff <= !is_load_ff && (rng_rsp.value != tracked_ff);
               end
            end
            qevt_pkg::ST_BUTTON: begin
               if (raw_moved) begin
                  raw_prev_ff    <= item_ff.button_raw;
                  change_time_ff <= item_ff.now_ms;
               end
               if (settle) deb_ff <= item_ff.button_raw;
               if (press) held_ff <= 1'b1;
               if (release_evt) held_ff <= 1'b0;
               btn_pend_ff <= press || release_evt;
            end
            default: begin
               held_ff <= held_ff;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff    <= req_payload;
         is_load_ff <= (req_payload.action == qevt_pkg::ACT_LOAD);
      end
      if (state_ff == qevt_pkg::ST_DECODE) step_dn_ff <= step_dn;
      if ((state_ff == qevt_pkg::ST_RANGE) && rng_rsp.done) rot_value_ff <= rng_rsp.value;
      if (state_ff == qevt_pkg::ST_BUTTON)
         btn_kind_ff <= press ? qevt_pkg::EVT_PRESS : qevt_pkg::EVT_RELEASE;
      if (rsp_load) rsp_payload_ff <= rsp_next;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
